// ===== rtl/gfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gfp_pkg
// Request, response, command and status types for the first-fit grid placer.
// ----------------------------------------------------------------------------
package gfp_pkg;

    localparam logic MODE_PLACE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [3:0] rect_width;
        logic [3:0] rect_height;
    } t_req;

    typedef struct packed {
        logic       placed;
        logic [6:0] slot_index;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic acc;
        logic check;
        logic mark;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic k_last;
        logic row_last;
        logic fit;
    } t_sts;

endpackage

// ===== rtl/gfp_datapath.sv =====
// ----------------------------------------------------------------------------
// gfp_datapath
// Occupancy grid, row accumulator, column fit search and response register.
// ----------------------------------------------------------------------------
module gfp_datapath #(
    parameter int GRID_ROWS = 15,
    parameter int GRID_COLS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gfp_pkg::t_req i_req,
    input  gfp_pkg::t_cmd i_cmd,
    output gfp_pkg::t_sts o_sts,
    output gfp_pkg::t_rsp o_rsp
);
    import gfp_pkg::*;

    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int LW = ((RW > 4) ? RW : 4) + 1;
    localparam int PW = RW + 6;

    logic [GRID_COLS-1:0] r_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] r_acc;
    logic [RW-1:0]        r_row;
    logic [3:0]           r_k;
    logic [3:0]           r_w;
    logic [3:0]           r_h;
    logic [CW-1:0]        r_col;
    logic                 r_found;
    t_rsp                 r_rsp;

    logic [LW-1:0]        row_sum;
    logic [RW-1:0]        idx;
    logic [GRID_COLS-1:0] span;
    logic [GRID_COLS-1:0] mark_mask;
    logic [GRID_COLS-1:0] fit_vec;
    logic [CW-1:0]        first_col;
    logic [PW-1:0]        slot_full;
    logic                 size_bad;
    logic [GRID_ROWS-1:0] row_busy;

    assign row_sum   = LW'(r_row) + LW'(r_k);
    assign idx       = row_sum[RW-1:0];
    assign span      = {GRID_COLS{1'b1}} >> (GRID_COLS - int'(r_w));
    assign mark_mask = span << r_col;
    assign slot_full = PW'(r_row) * PW'(GRID_COLS) + PW'(r_col);

    always_comb begin
        fit_vec   = '0;
        first_col = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            fit_vec[c] = (c + int'(r_w) <= GRID_COLS) && ((r_acc & (span << c)) == '0);
        end
        for (int c = GRID_COLS - 1; c >= 0; c--) begin
            if (fit_vec[c]) begin
                first_col = CW'(c);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < GRID_ROWS; r++) begin
            row_busy[r] = |r_grid[r];
        end
    end

    assign size_bad = (i_req.rect_width == 4'd0) || (i_req.rect_height == 4'd0)
                   || (int'(i_req.rect_width) > GRID_COLS)
                   || (int'(i_req.rect_height) > GRID_ROWS);

    assign o_sts.skip     = (i_req.mode == MODE_CLEAR) || size_bad;
    assign o_sts.k_last   = (r_k + 4'd1) == r_h;
    assign o_sts.row_last = (LW'(r_row) + LW'(r_h)) == LW'(GRID_ROWS);
    assign o_sts.fit      = |fit_vec;
    assign o_rsp          = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_grid[r] <= '0;
            end
        end else if (i_cmd.load && i_req.mode == MODE_CLEAR) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_grid[r] <= '0;
            end
        end else if (i_cmd.mark) begin
            r_grid[idx] <= r_grid[idx] | mark_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.check && o_sts.fit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w   <= i_req.rect_width;
            r_h   <= i_req.rect_height;
            r_row <= '0;
            r_k   <= '0;
            r_acc <= '0;
            r_col <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc | r_grid[idx];
            r_k   <= r_k + 4'd1;
        end else if (i_cmd.check) begin
            r_k <= '0;
            if (o_sts.fit) begin
                r_col <= first_col;
            end else begin
                r_row <= r_row + RW'(1);
                r_acc <= '0;
            end
        end else if (i_cmd.mark) begin
            r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.placed     <= r_found;
            r_rsp.slot_index <= r_found ? slot_full[6:0] : 7'd0;
        end
    end

    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |-> ((r_grid[idx] & mark_mask) == '0))
        else $error("marking an occupied cell");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_req.mode == MODE_CLEAR) |=> (row_busy == '0))
        else $error("grid not empty after clear");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc || i_cmd.mark) |-> (row_sum < LW'(GRID_ROWS)))
        else $error("grid row index out of range");

endmodule

// ===== rtl/gfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gfp_ctrl
// Sequencer for load, row accumulation, fit check, marking and response.
// ----------------------------------------------------------------------------
module gfp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  gfp_pkg::t_sts i_sts,
    output gfp_pkg::t_cmd o_cmd
);
    import gfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CHECK,
        S_MARK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.skip ? S_DONE : S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.fit) begin
                    n_state = S_MARK;
                end else if (i_sts.row_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/grid_first_fit_placer_top.sv =====
// ----------------------------------------------------------------------------
// grid_first_fit_placer_top
// First-fit rectangle placement on a row-by-column occupancy bitmap.
// ----------------------------------------------------------------------------
// A place request scans anchors row by row and column by column and takes the
// first free spot, marks its cells and returns row*GRID_COLS+col; a clear
// request empties the grid. One request is in flight at a time. A clear or an
// impossible size skips the search. A placement reads one grid row per cycle:
// for each of up to GRID_ROWS-h+1 candidate anchor rows, h rows are ORed and
// then all columns are checked at once; after a fit the h rows are marked.
// The response sits in an output register, so a new request may enter while
// it waits.
// ----------------------------------------------------------------------------
module grid_first_fit_placer_top #(
    parameter int GRID_ROWS = 15,
    parameter int GRID_COLS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gfp_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gfp_pkg::t_rsp o_out_rsp
);
    import gfp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gfp_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_rsp)
    );

endmodule

// ===== sim/gfp_checker.sv =====
// ----------------------------------------------------------------------------
// gfp_checker
// Watches both channels of the first-fit grid placer, keeps its own copy of
// the occupancy grid, predicts the response of every accepted request and
// compares each accepted response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gfp_checker
    import gfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_req  i_in_req,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_rsp  i_out_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 15;
    localparam int COLS = 8;

    logic [COLS-1:0] occ_rows [ROWS];
    t_rsp            pending_placements [$];
    int              fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_placements.size();

    task automatic report_mismatch(input string what);
        $display("gfp_checker: %0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic predict_placement(input t_req req, output t_rsp rsp);
        logic [15:0] span;
        logic [15:0] mask;
        logic        found;
        logic        fits;
        rsp   = '0;
        found = 1'b0;
        if (req.mode == MODE_CLEAR) begin
            for (int r = 0; r < ROWS; r++) occ_rows[r] = '0;
        end else if (req.rect_width != 0 && req.rect_height != 0 &&
                     req.rect_width <= COLS && req.rect_height <= ROWS) begin
            span = (16'd1 << req.rect_width) - 16'd1;
            for (int r = 0; r + req.rect_height <= ROWS && !found; r++) begin
                for (int c = 0; c + req.rect_width <= COLS && !found; c++) begin
                    mask = span << c;
                    fits = 1'b1;
                    for (int k = 0; k < req.rect_height; k++) begin
                        if ((occ_rows[r+k] & mask[COLS-1:0]) != '0) fits = 1'b0;
                    end
                    if (fits) begin
                        found = 1'b1;
                        for (int k = 0; k < req.rect_height; k++) begin
                            occ_rows[r+k] = occ_rows[r+k] | mask[COLS-1:0];
                        end
                        rsp.placed     = 1'b1;
                        rsp.slot_index = 7'(r * COLS + c);
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) occ_rows[r] = '0;
            pending_placements.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_rsp;
                if (pending_placements.size() == 0) begin
                    report_mismatch($sformatf("response %0b/%0d with no request outstanding",
                                              got.placed, got.slot_index));
                end else begin
                    want = pending_placements.pop_front();
                    if (got.placed !== want.placed)
                        report_mismatch($sformatf("placed %0b, want %0b",
                                                  got.placed, want.placed));
                    if (got.slot_index !== want.slot_index)
                        report_mismatch($sformatf("slot_index %0d, want %0d",
                                                  got.slot_index, want.slot_index));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_placement(i_in_req, want);
                pending_placements.push_back(want);
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives place and clear requests into the first-fit grid placer: a directed
// run over full grids, zero and oversized rectangles and the size extremes,
// then random fill-and-clear traffic under three idle patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_COUNT = 443;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_req    = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_rsp;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending;
    int quiet_cycles   = 0;

    grid_first_fit_placer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    gfp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_rsp    (o_out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_req make_req(input logic mode, input int w, input int h);
        t_req req;
        req.mode        = mode;
        req.rect_width  = 4'(w);
        req.rect_height = 4'(h);
        return req;
    endfunction

    // enter and leave at a falling edge
    task automatic send_request(input t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_request(make_req(MODE_CLEAR, $urandom_range(15), $urandom_range(15)));
            end else if (pick < 12) begin
                send_request(make_req(MODE_PLACE, $urandom_range(15), $urandom_range(15)));
            end else if (pick < 35) begin
                send_request(make_req(MODE_PLACE, $urandom_range(1, 8), $urandom_range(1, 15)));
            end else begin
                send_request(make_req(MODE_PLACE, $urandom_range(1, 4), $urandom_range(1, 5)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 24;
        recv_stall_pct = 77;

        send_request(make_req(MODE_CLEAR, 0, 0));
        send_request(make_req(MODE_PLACE, 8, 15));
        send_request(make_req(MODE_PLACE, 1, 1));
        send_request(make_req(MODE_CLEAR, 15, 15));
        send_request(make_req(MODE_PLACE, 0, 3));
        send_request(make_req(MODE_PLACE, 3, 0));
        send_request(make_req(MODE_PLACE, 0, 0));
        send_request(make_req(MODE_PLACE, 9, 1));
        send_request(make_req(MODE_PLACE, 15, 15));
        send_request(make_req(MODE_PLACE, 1, 15));
        send_request(make_req(MODE_PLACE, 8, 1));
        send_request(make_req(MODE_PLACE, 4, 2));
        send_request(make_req(MODE_PLACE, 1, 1));
        send_request(make_req(MODE_PLACE, 1, 1));
        send_request(make_req(MODE_PLACE, 2, 1));
        send_request(make_req(MODE_PLACE, 8, 15));
        send_request(make_req(MODE_CLEAR, 8, 1));
        send_request(make_req(MODE_PLACE, 7, 14));
        send_request(make_req(MODE_PLACE, 1, 14));
        send_request(make_req(MODE_PLACE, 8, 1));
        send_request(make_req(MODE_PLACE, 1, 1));
        send_request(make_req(MODE_CLEAR, 0, 15));
        send_request(make_req(MODE_PLACE, 5, 3));

        send_random(RANDOM_COUNT);

        send_idle_pct  = 77;
        recv_stall_pct = 24;
        send_random(RANDOM_COUNT);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(RANDOM_COUNT);

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
